// ===== rtl/smcn_pkg.sv =====
// shared types, constants and the control program of the calibration block
// no dependencies
`timescale 1ns / 1ps

package smcn_pkg;

    localparam int NUM_CHANNELS_DEF  = 8;
    localparam int FULL_SCALE_MV_DEF = 3300;
    localparam int TENTHS_PER_MV     = 10;
    localparam int MIN_SPAN_MV       = 10;
    localparam int SAMPLE_W          = 12;
    localparam int VALUE_W           = 16;
    localparam int CHAN_W            = 3;
    localparam int PROD_W            = SAMPLE_W + VALUE_W;
    localparam int STEP_W            = 4;
    localparam int DIV_CNT_W         = 4;

    typedef enum logic [1:0] {
        CMD_START      = 2'd0,
        CMD_CAL_SAMPLE = 2'd1,
        CMD_FINISH     = 2'd2,
        CMD_MEASURE    = 2'd3
    } t_cmd_code;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample_mv;
    } t_in;

    typedef struct packed {
        logic [VALUE_W-1:0] value_tenth_mv;
        logic               calibrated;
    } t_out;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_FETCH,
        OP_READ,
        OP_MUL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_CLEAR,
        OP_SET_CAL,
        OP_UPDATE,
        OP_EMIT_QUOT,
        OP_EMIT_ECHO,
        OP_EMIT_ZERO,
        OP_EMIT_TOP
    } t_op;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NO_REQ,
        C_CMD_START,
        C_CMD_CAL,
        C_CMD_FINISH,
        C_UNCAL,
        C_ZERO,
        C_CLAMP,
        C_DIV_MORE
    } t_cond;

    typedef struct packed {
        t_op               op;
        logic              wait_out;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        t_op  op;
        logic go;
    } t_uop;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] cmd;
        logic       cal;
        logic       zero;
        logic       clamp;
        logic       div_more;
        logic       out_busy;
    } t_status;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } t_store_req;

    typedef struct packed {
        logic [SAMPLE_W-1:0] minimum;
        logic [SAMPLE_W-1:0] maximum;
    } t_store_rd;

    localparam logic [STEP_W-1:0] S_FETCH     = 4'd0;
    localparam logic [STEP_W-1:0] S_DIV_LOOP  = 4'd7;
    localparam logic [STEP_W-1:0] S_CLEAR     = 4'd10;
    localparam logic [STEP_W-1:0] S_SET_CAL   = 4'd11;
    localparam logic [STEP_W-1:0] S_UPDATE    = 4'd12;
    localparam logic [STEP_W-1:0] S_EMIT_ECHO = 4'd13;
    localparam logic [STEP_W-1:0] S_EMIT_ZERO = 4'd14;
    localparam logic [STEP_W-1:0] S_EMIT_TOP  = 4'd15;

    function automatic t_ctrl smcn_rom(input logic [STEP_W-1:0] step);
        t_ctrl w;
        w = '{op: OP_NOP, wait_out: 1'b0, cond: C_ALWAYS, target: S_FETCH};
        case (step)
            4'd0:  w = '{op: OP_FETCH,     wait_out: 1'b0, cond: C_NO_REQ,     target: S_FETCH};
            4'd1:  w = '{op: OP_NOP,       wait_out: 1'b0, cond: C_CMD_START,  target: S_CLEAR};
            4'd2:  w = '{op: OP_NOP,       wait_out: 1'b0, cond: C_CMD_FINISH, target: S_SET_CAL};
            4'd3:  w = '{op: OP_READ,      wait_out: 1'b0, cond: C_CMD_CAL,    target: S_UPDATE};
            4'd4:  w = '{op: OP_MUL,       wait_out: 1'b0, cond: C_UNCAL,
                         target: S_EMIT_ECHO};
            4'd5:  w = '{op: OP_DIV_INIT,  wait_out: 1'b0, cond: C_ZERO,
                         target: S_EMIT_ZERO};
            4'd6:  w = '{op: OP_NOP,       wait_out: 1'b0, cond: C_CLAMP,
                         target: S_EMIT_TOP};
            4'd7:  w = '{op: OP_DIV_STEP,  wait_out: 1'b0, cond: C_DIV_MORE,
                         target: S_DIV_LOOP};
            4'd8:  w = '{op: OP_EMIT_QUOT, wait_out: 1'b1, cond: C_ALWAYS, target: S_FETCH};
            4'd9:  w = '{op: OP_NOP,       wait_out: 1'b0, cond: C_ALWAYS, target: S_FETCH};
            4'd10: w = '{op: OP_CLEAR,     wait_out: 1'b0, cond: C_ALWAYS,
                         target: S_EMIT_ZERO};
            4'd11: w = '{op: OP_SET_CAL,   wait_out: 1'b0, cond: C_ALWAYS,
                         target: S_EMIT_ZERO};
            4'd12: w = '{op: OP_UPDATE,    wait_out: 1'b0, cond: C_ALWAYS,
                         target: S_EMIT_ECHO};
            4'd13: w = '{op: OP_EMIT_ECHO, wait_out: 1'b1, cond: C_ALWAYS, target: S_FETCH};
            4'd14: w = '{op: OP_EMIT_ZERO, wait_out: 1'b1, cond: C_ALWAYS, target: S_FETCH};
            4'd15: w = '{op: OP_EMIT_TOP,  wait_out: 1'b1, cond: C_ALWAYS, target: S_FETCH};
            default: w = '{op: OP_NOP, wait_out: 1'b0, cond: C_ALWAYS, target: S_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/sensor_minmax_calibrate_normalize.sv =====
// a calibrated measurement that is forced to zero or clamped skips the divider; any other
// calibrated measurement runs the 16-step serial divider loop; a stalled output adds its wait
// throughput: one request at a time, next request taken when the program returns to fetch
// reset: synchronous active low, clears all stored minima/maxima to their reset values
// through valid bits at once and clears the calibrated flag; no clearing pass
`timescale 1ns / 1ps

module sensor_minmax_calibrate_normalize
    import smcn_pkg::*;
#(
    parameter int NUM_CHANNELS  = NUM_CHANNELS_DEF,
    parameter int FULL_SCALE_MV = FULL_SCALE_MV_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_uop            w_uop;
    t_status         w_stat;
    t_store_req      w_req;
    logic [CH_W-1:0] w_idx;
    t_store_rd       w_wr_data;
    t_store_rd       w_rd_data;

    smcn_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_uop   (w_uop)
    );

    smcn_dp #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .FULL_SCALE_MV (FULL_SCALE_MV),
        .CH_W          (CH_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uop       (w_uop),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_rd_data   (w_rd_data),
        .o_store_req (w_req),
        .o_idx       (w_idx),
        .o_wr_data   (w_wr_data),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    smcn_store #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .FULL_SCALE_MV (FULL_SCALE_MV),
        .CH_W          (CH_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_idx     (w_idx),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    assign o_in_ready = (w_uop.op == OP_FETCH);

    a_leave_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("sequencer stayed in fetch after a request");

    a_cal_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(w_stat.cal))
        else $error("calibrated flag dropped without reset");

    a_div_only_inrange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_uop.op == OP_DIV_STEP) |-> (!w_stat.zero && !w_stat.clamp))
        else $error("divider running on a zero or clamped result");

    a_no_store_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_req.rd_en && (w_req.wr_en || w_req.clear)))
        else $error("store read collides with a write or clear");

endmodule

// ===== rtl/smcn_store.sv =====
// per-channel minimum and maximum store with valid bits, registered read
// depends on smcn_pkg
`timescale 1ns / 1ps

module smcn_store
    import smcn_pkg::*;
#(
    parameter int NUM_CHANNELS  = NUM_CHANNELS_DEF,
    parameter int FULL_SCALE_MV = FULL_SCALE_MV_DEF,
    parameter int CH_W          = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_store_req          i_req,
    input  logic [CH_W-1:0]     i_idx,
    input  t_store_rd           i_wr_data,
    output t_store_rd           o_rd_data
);

    localparam logic [SAMPLE_W-1:0] RESET_MIN = SAMPLE_W'(FULL_SCALE_MV);

    logic [SAMPLE_W-1:0]     r_min_mem [NUM_CHANNELS];
    logic [SAMPLE_W-1:0]     r_max_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_vld;
    logic [SAMPLE_W-1:0]     r_min_q;
    logic [SAMPLE_W-1:0]     r_max_q;
    logic                    r_vld_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.clear) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_min_mem[i_idx] <= i_wr_data.minimum;
            r_max_mem[i_idx] <= i_wr_data.maximum;
        end
        if (i_req.rd_en) begin
            r_min_q <= r_min_mem[i_idx];
            r_max_q <= r_max_mem[i_idx];
            r_vld_q <= r_vld[i_idx];
        end
    end

    // entries not written since the last clear read as the reset values
    assign o_rd_data.minimum = r_vld_q ? r_min_q : RESET_MIN;
    assign o_rd_data.maximum = r_vld_q ? r_max_q : '0;

endmodule

// ===== rtl/smcn_seq.sv =====
// microcode sequencer: step counter, control rom and conditional jumps
// depends on smcn_pkg
`timescale 1ns / 1ps

module smcn_seq
    import smcn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_stat,
    output t_uop    o_uop
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             w_word;
    logic              w_stall;
    logic              w_take;

    assign w_word  = smcn_rom(r_step);
    assign w_stall = w_word.wait_out && i_stat.out_busy;

    always_comb begin
        case (w_word.cond)
            C_ALWAYS:     w_take = 1'b1;
            C_NO_REQ:     w_take = !i_stat.in_valid;
            C_CMD_START:  w_take = (i_stat.cmd == CMD_START);
            C_CMD_CAL:    w_take = (i_stat.cmd == CMD_CAL_SAMPLE);
            C_CMD_FINISH: w_take = (i_stat.cmd == CMD_FINISH);
            C_UNCAL:      w_take = !i_stat.cal;
            C_ZERO:       w_take = i_stat.zero;
            C_CLAMP:      w_take = i_stat.clamp;
            C_DIV_MORE:   w_take = i_stat.div_more;
            default:      w_take = 1'b0;
        endcase
        if (w_stall) begin
            n_step = r_step;
        end else if (w_take) begin
            n_step = w_word.target;
        end else begin
            n_step = r_step + 1'b1;
        end
        o_uop.op = w_word.op;
        o_uop.go = !w_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ===== rtl/smcn_dp.sv =====
// datapath: request latch, scale multiply, serial divider, output register
// depends on smcn_pkg
`timescale 1ns / 1ps

module smcn_dp
    import smcn_pkg::*;
#(
    parameter int NUM_CHANNELS  = NUM_CHANNELS_DEF,
    parameter int FULL_SCALE_MV = FULL_SCALE_MV_DEF,
    parameter int CH_W          = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_uop            i_uop,
    input  logic            i_in_valid,
    input  t_in             i_in_data,
    input  logic            i_out_ready,
    input  t_store_rd       i_rd_data,
    output t_store_req      o_store_req,
    output logic [CH_W-1:0] o_idx,
    output t_store_rd       o_wr_data,
    output t_status         o_stat,
    output logic            o_out_valid,
    output t_out            o_out_data
);

    localparam logic [VALUE_W-1:0]  TOP      = VALUE_W'(FULL_SCALE_MV * TENTHS_PER_MV);
    localparam logic [SAMPLE_W:0]   MIN_SPAN = (SAMPLE_W + 1)'(MIN_SPAN_MV);
    localparam logic [6:0]          NCH      = 7'(NUM_CHANNELS);

    t_in                  r_in;
    logic                 r_cal;
    logic                 r_zero;
    logic                 r_clamp;
    logic [SAMPLE_W-1:0]  r_span;
    logic [PROD_W-1:0]    r_prod;
    logic [SAMPLE_W-1:0]  r_rem;
    logic [VALUE_W-1:0]   r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_out_valid;
    t_out                 r_out;

    logic [6:0]           w_ch_ext;
    logic                 w_ch_ok;
    logic [SAMPLE_W-1:0]  w_s;
    logic [SAMPLE_W-1:0]  w_lo;
    logic [SAMPLE_W-1:0]  w_hi;
    logic [SAMPLE_W-1:0]  w_diff;
    logic                 w_zero;
    logic [VALUE_W-1:0]   w_echo;
    logic [SAMPLE_W:0]    w_trial;
    logic                 w_fit;
    logic                 w_out_busy;
    logic                 w_emit;
    logic [VALUE_W-1:0]   w_emit_val;

    assign w_ch_ext = {{(7 - CHAN_W){1'b0}}, r_in.channel};
    assign w_ch_ok  = (w_ch_ext < NCH);
    assign o_idx    = w_ch_ext[CH_W-1:0];

    assign w_s    = r_in.sample_mv;
    assign w_lo   = i_rd_data.minimum;
    assign w_hi   = i_rd_data.maximum;
    assign w_diff = w_s - w_lo;
    assign w_zero = !w_ch_ok || ({1'b0, w_hi} < ({1'b0, w_lo} + MIN_SPAN)) || (w_s <= w_lo);
    assign w_echo = VALUE_W'({w_s, 3'b000}) + VALUE_W'({w_s, 1'b0});

    // one restoring step of the long division
    assign w_trial = {r_rem, r_quo[VALUE_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_span});

    assign o_store_req.rd_en = i_uop.go && (i_uop.op == OP_READ);
    assign o_store_req.wr_en = i_uop.go && (i_uop.op == OP_UPDATE) && w_ch_ok;
    assign o_store_req.clear = i_uop.go && (i_uop.op == OP_CLEAR);
    assign o_wr_data.minimum = (w_s < w_lo) ? w_s : w_lo;
    assign o_wr_data.maximum = (w_s > w_hi) ? w_s : w_hi;

    assign w_out_busy = r_out_valid && !i_out_ready;

    always_comb begin
        w_emit = i_uop.go;
        case (i_uop.op)
            OP_EMIT_QUOT: w_emit_val = r_quo;
            OP_EMIT_ECHO: w_emit_val = w_echo;
            OP_EMIT_TOP:  w_emit_val = TOP;
            OP_EMIT_ZERO: w_emit_val = '0;
            default: begin
                w_emit_val = '0;
                w_emit     = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_uop.go && (i_uop.op == OP_SET_CAL)) begin
                r_cal <= 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_uop.op == OP_FETCH && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (i_uop.op == OP_MUL) begin
            r_zero  <= w_zero;
            r_clamp <= (w_diff >= (w_hi - w_lo));
            r_span  <= w_hi - w_lo;
            r_prod  <= PROD_W'(w_diff) * PROD_W'(TOP);
        end
        if (i_uop.op == OP_DIV_INIT) begin
            r_rem <= r_prod[PROD_W-1:VALUE_W];
            r_quo <= r_prod[VALUE_W-1:0];
            r_cnt <= '0;
        end
        if (i_uop.op == OP_DIV_STEP) begin
            r_rem <= w_fit ? SAMPLE_W'(w_trial - {1'b0, r_span}) : w_trial[SAMPLE_W-1:0];
            r_quo <= {r_quo[VALUE_W-2:0], w_fit};
            r_cnt <= r_cnt + 1'b1;
        end
        if (w_emit) begin
            r_out.value_tenth_mv <= w_emit_val;
            r_out.calibrated     <= r_cal;
        end
    end

    assign o_stat.in_valid = i_in_valid;
    assign o_stat.cmd      = r_in.cmd;
    assign o_stat.cal      = r_cal;
    assign o_stat.zero     = r_zero;
    assign o_stat.clamp    = r_clamp;
    assign o_stat.div_more = (r_cnt != {DIV_CNT_W{1'b1}});
    assign o_stat.out_busy = w_out_busy;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
